// File: hw/rtl/b64sc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types, constants and character tables for the base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

    localparam logic [7:0] PAD_CHAR  = 8'h3D;
    localparam logic       MODE_ENC  = 1'b0;
    localparam logic       MODE_DEC  = 1'b1;

    // results of one completed group, handed from the group logic to the queue
    typedef struct packed {
        logic            valid;
        logic [3:0][7:0] data;     // entry k is result k
        logic [1:0]      num_m1;   // number of results minus one
        logic            last;     // message ends with the final result
        logic            bad;      // bad input flag for every result
    } grp_out_t;

    // standard alphabet: sextet to character
    function automatic logic [7:0] enc_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26)
            c = 8'h41 + {2'b00, s};
        else if (s < 6'd52)
            c = 8'h61 + {2'b00, s - 6'd26};
        else if (s < 6'd62)
            c = 8'h30 + {2'b00, s - 6'd52};
        else if (s == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

    // character to {valid, sextet}; pad reads as valid zero
    function automatic logic [6:0] dec_char(input logic [7:0] c);
        logic [7:0] t;
        logic [6:0] r;
        t = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            t = c - 8'h41;
            r = {1'b1, t[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            t = c - 8'h61 + 8'd26;
            r = {1'b1, t[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30 + 8'd52;
            r = {1'b1, t[5:0]};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end else if (c == PAD_CHAR) begin
            r = {1'b1, 6'd0};
        end else begin
            r = {1'b0, t[5:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/b64sc_group.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_group
// Mode register and group gathering; produces a full group of results in
// the cycle its completing item is accepted.
// ----------------------------------------------------------------------------
module b64sc_group (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                mode_we,
    input  wire logic                mode_wdata,
    input  wire logic                item_accept,
    input  wire logic [7:0]          in_byte,
    input  wire logic                in_last,
    output b64sc_pkg::grp_out_t      grp_out
);
    import b64sc_pkg::*;

    logic        mode_reg;
    logic [23:0] bits_reg,  bits_next;
    logic [1:0]  count_reg, count_next;
    logic        tpad_reg,  tpad_next;
    logic        err_reg,   err_next;

    logic [23:0] bits_new;
    logic [6:0]  dec;
    logic        is_pad;
    logic        complete;
    logic        tpad_new;
    logic        err_new;
    grp_out_t    res;

    assign dec    = dec_char(in_byte);
    assign is_pad = (in_byte == PAD_CHAR);

    // merge the item into the group and build the results
    always_comb
    begin
        bits_new = bits_reg;
        tpad_new = tpad_reg;
        err_new  = err_reg;
        res      = '0;
        complete = 1'b0;
        if (mode_reg == MODE_ENC) begin
            case (count_reg)
                2'd0:    bits_new[23:16] = bits_reg[23:16] | in_byte;
                2'd1:    bits_new[15:8]  = bits_reg[15:8]  | in_byte;
                default: bits_new[7:0]   = bits_reg[7:0]   | in_byte;
            endcase
            complete    = (count_reg == 2'd2) || in_last;
            res.data[0] = enc_char(bits_new[23:18]);
            res.data[1] = enc_char(bits_new[17:12]);
            res.data[2] = (count_reg == 2'd0) ? PAD_CHAR : enc_char(bits_new[11:6]);
            res.data[3] = (count_reg != 2'd2) ? PAD_CHAR : enc_char(bits_new[5:0]);
            res.num_m1  = 2'd3;
            res.bad     = 1'b0;
        end else begin
            case (count_reg)
                2'd0:    bits_new[23:18] = bits_reg[23:18] | dec[5:0];
                2'd1:    bits_new[17:12] = bits_reg[17:12] | dec[5:0];
                2'd2:    bits_new[11:6]  = bits_reg[11:6]  | dec[5:0];
                default: bits_new[5:0]   = bits_reg[5:0]   | dec[5:0];
            endcase
            err_new  = err_reg | ~dec[6];
            tpad_new = tpad_reg | ((count_reg == 2'd2) && is_pad);
            complete = (count_reg == 2'd3) || in_last;
            res.data[0] = bits_new[23:16];
            res.data[1] = bits_new[15:8];
            res.data[2] = bits_new[7:0];
            res.data[3] = 8'h00;
            // trailing pad drops one byte, a third-place pad one more
            if (count_reg != 2'd3) begin
                res.num_m1 = 2'd2;
                res.bad    = 1'b1;
            end else begin
                res.bad = err_new;
                if (in_last && is_pad)
                    res.num_m1 = tpad_reg ? 2'd0 : 2'd1;
                else
                    res.num_m1 = 2'd2;
            end
        end
        res.last  = in_last;
        res.valid = item_accept && complete;
    end

    assign grp_out = res;

    // next group state
    always_comb
    begin
        bits_next  = bits_reg;
        count_next = count_reg;
        tpad_next  = tpad_reg;
        err_next   = err_reg;
        if (mode_we) begin
            bits_next  = '0;
            count_next = '0;
            tpad_next  = 1'b0;
            err_next   = 1'b0;
        end else if (item_accept) begin
            if (complete) begin
                bits_next  = '0;
                count_next = '0;
                tpad_next  = 1'b0;
                err_next   = 1'b0;
            end else begin
                bits_next  = bits_new;
                count_next = count_reg + 2'd1;
                tpad_next  = tpad_new;
                err_next   = err_new;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_ENC;
            bits_reg  <= '0;
            count_reg <= '0;
            tpad_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end else begin
            if (mode_we)
                mode_reg <= mode_wdata;
            bits_reg  <= bits_next;
            count_reg <= count_next;
            tpad_reg  <= tpad_next;
            err_reg   <= err_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/base64_stream_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder/decoder, standard alphabet, selected by mode.
// ----------------------------------------------------------------------------
// Usage:
//   mode_we/mode_wdata write the mode (0 encode, 1 decode) while idle; any
//   write drops a half-gathered group. Items enter on s_axis (tdata = byte or
//   character, tlast = end of message); results leave on m_axis (tdata =
//   character or byte, tlast = end of message, tuser = bad input flag).
//   An item is gathered in the cycle it is accepted. The request that
//   completes a group loads a pending group register, which moves to the
//   output buffer once that is free; the results then leave one per cycle
//   while the receiver is ready.
//   Input takes one request per cycle while the pending register is free.
//   The single output port sets the rate: encoding drains four results per
//   three bytes. Decoding pauses the input after each completed group, while
//   the group waits in the pending register.
//   If the receiver stalls, the output buffer and then the
//   pending register hold and s_axis_tready drops; nothing is lost.
//   Reset clears mode to encode and empties the group and both buffers.
// ----------------------------------------------------------------------------
module base64_stream_codec (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       mode_we,
    input  wire logic       mode_wdata,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,    // [7:0] in_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,    // [7:0] out_byte
    output logic            m_axis_tlast,
    output logic            m_axis_tuser     // [0] bad_input
);
    import b64sc_pkg::*;

    grp_out_t        grp_out;
    logic            in_accept;

    logic            pend_valid_reg;
    logic [3:0][7:0] pend_data_reg;
    logic [1:0]      pend_num_reg;
    logic            pend_last_reg;
    logic            pend_bad_reg;

    logic            act_valid_reg;
    logic [3:0][7:0] act_data_reg;
    logic [1:0]      act_num_reg;
    logic [1:0]      act_idx_reg;
    logic            act_last_reg;
    logic            act_bad_reg;

    logic            act_final;
    logic            act_done;
    logic            act_load;

    assign s_axis_tready = ~pend_valid_reg;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    // group gathering
    b64sc_group u_group (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode_we     (mode_we),
        .mode_wdata  (mode_wdata),
        .item_accept (in_accept),
        .in_byte     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .grp_out     (grp_out)
    );

    // output buffer handshake
    assign act_final = (act_idx_reg == act_num_reg);
    assign act_done  = act_valid_reg & m_axis_tready & act_final;
    assign act_load  = pend_valid_reg & (~act_valid_reg | act_done);

    assign m_axis_tvalid = act_valid_reg;
    assign m_axis_tdata  = act_data_reg[act_idx_reg];
    assign m_axis_tlast  = act_last_reg & act_final;
    assign m_axis_tuser  = act_bad_reg;

    // pending group register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (grp_out.valid)
            pend_valid_reg <= 1'b1;
        else if (act_load)
            pend_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (grp_out.valid) begin
            pend_data_reg <= grp_out.data;
            pend_num_reg  <= grp_out.num_m1;
            pend_last_reg <= grp_out.last;
            pend_bad_reg  <= grp_out.bad;
        end
    end

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            act_valid_reg <= 1'b0;
            act_idx_reg   <= '0;
        end else if (act_load) begin
            act_valid_reg <= 1'b1;
            act_idx_reg   <= '0;
        end else if (act_done) begin
            act_valid_reg <= 1'b0;
            act_idx_reg   <= '0;
        end else if (act_valid_reg && m_axis_tready) begin
            act_idx_reg   <= act_idx_reg + 2'd1;
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (act_load) begin
            act_data_reg <= pend_data_reg;
            act_num_reg  <= pend_num_reg;
            act_last_reg <= pend_last_reg;
            act_bad_reg  <= pend_bad_reg;
        end
    end

endmodule
`default_nettype wire
